[rtl/prc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prc_pkg: shared constants, types and tables for the polar/rect converter
// Holds the fixed-point format, the gain-inverse constant and the arctangent
// table used by the CORDIC iteration stages.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int ITERATIONS_DEF = 16;

    // fraction bits held below the integer part of every internal coordinate
    localparam int GUARD      = 24;
    // binary angle width, 2^(ANG_W-1) = pi
    localparam int ANG_W      = 32;
    // prescale product is rounded and shifted down by this many bits
    localparam int PRE_SHIFT  = 32 - GUARD;
    localparam int TABLE_LEN  = 24;

    // 1/K in Q0.32
    localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

    typedef struct packed {
        logic valid;   // stage holds a word
        logic vec;     // vectoring (rect to polar)
        logic bypass;  // axis case, result already formed
    } ctl_t;

    // round(atan(2^-i) * 2^31 / pi)
    function automatic logic [ANG_W-1:0] atan_entry(input int idx);
        logic [ANG_W-1:0] val;
        case (idx)
            0:       val = 32'h20000000;
            1:       val = 32'h12E4051E;
            2:       val = 32'h09FB385B;
            3:       val = 32'h051111D4;
            4:       val = 32'h028B0D43;
            5:       val = 32'h0145D7E1;
            6:       val = 32'h00A2F61E;
            7:       val = 32'h00517C55;
            8:       val = 32'h0028BE53;
            9:       val = 32'h00145F2F;
            10:      val = 32'h000A2F98;
            11:      val = 32'h000517CC;
            12:      val = 32'h00028BE6;
            13:      val = 32'h000145F3;
            14:      val = 32'h0000A2FA;
            15:      val = 32'h0000517D;
            16:      val = 32'h000028BE;
            17:      val = 32'h0000145F;
            18:      val = 32'h00000A30;
            19:      val = 32'h00000518;
            20:      val = 32'h0000028C;
            21:      val = 32'h00000146;
            22:      val = 32'h000000A3;
            23:      val = 32'h00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

[rtl/polar_rect_converter_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polar_rect_converter_core: pipelined CORDIC polar/rectangular converter
// s_action = 0: (s_a_in, s_b_in) = (x, y) -> magnitude, atan2 angle.
// s_action = 1: (s_a_in, s_b_in) = (r, theta) -> r*cos, r*sin.
// Angles are binary: 2^(DATA_WIDTH-1) stands for pi.
//
// Both channels are valid/ready; a word moves when valid and ready are high.
// Throughput is one word per cycle unless a receiver stall fills the skid.
// From input acceptance to m_valid a word passes three decode/prescale
// stages, one stage per micro-rotation and one output register; ITERATIONS is capped at 24.
// Reset (aresetn low, synchronous) empties the pipeline and drops m_valid.
// When the receiver stalls, the output register holds its word and one
// more word lands in a skid register; s_ready then drops and the whole
// pipeline freezes in place until the skid drains, so nothing is lost.
// s_ready comes straight from a register, with no path from m_ready.
// ----------------------------------------------------------------------------
module polar_rect_converter_core #(
    parameter int DATA_WIDTH = prc_pkg::DATA_WIDTH_DEF,
    parameter int ITERATIONS = prc_pkg::ITERATIONS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_action,
    input  wire signed [DATA_WIDTH-1:0]  s_a_in,
    input  wire signed [DATA_WIDTH-1:0]  s_b_in,

    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [DATA_WIDTH:0]   m_first_out,
    output logic signed [DATA_WIDTH:0]   m_second_out
);

    // guard bits below, headroom for negation and CORDIC growth above
    localparam int W     = DATA_WIDTH + prc_pkg::GUARD + 3;
    localparam int NITER = (ITERATIONS > prc_pkg::TABLE_LEN) ? prc_pkg::TABLE_LEN
                                                             : ITERATIONS;

    logic pipe_en;

    // stage taps: index 0 is the prescale output, NITER the last rotation
    prc_pkg::ctl_t               ctl_w [0:NITER];
    logic signed [W-1:0]         cx_w  [0:NITER];
    logic signed [W-1:0]         cy_w  [0:NITER];
    logic [prc_pkg::ANG_W-1:0]   z_w   [0:NITER];

    prc_prescale #(
        .DATA_WIDTH (DATA_WIDTH),
        .W          (W)
    ) u_prescale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_valid (s_valid),
        .action   (s_action),
        .a_in     (s_a_in),
        .b_in     (s_b_in),
        .ctl_o    (ctl_w[0]),
        .cx_o     (cx_w[0]),
        .cy_o     (cy_w[0]),
        .z_o      (z_w[0])
    );

    // one micro-rotation per stage, shift and table entry fixed per stage
    for (genvar i = 0; i < NITER; i++) begin : g_iter
        prc_cordic_stage #(
            .W   (W),
            .IDX (i)
        ) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (pipe_en),
            .ctl_i   (ctl_w[i]),
            .cx_i    (cx_w[i]),
            .cy_i    (cy_w[i]),
            .z_i     (z_w[i]),
            .ctl_o   (ctl_w[i+1]),
            .cx_o    (cx_w[i+1]),
            .cy_o    (cy_w[i+1]),
            .z_o     (z_w[i+1])
        );
    end

    prc_output #(
        .DATA_WIDTH (DATA_WIDTH),
        .W          (W)
    ) u_output (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl_i        (ctl_w[NITER]),
        .cx_i         (cx_w[NITER]),
        .cy_i         (cy_w[NITER]),
        .z_i          (z_w[NITER]),
        .pipe_en      (pipe_en),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_first_out  (m_first_out),
        .m_second_out (m_second_out)
    );

    // input is taken whenever the pipeline advances
    assign s_ready = pipe_en;

endmodule
`default_nettype wire

[rtl/prc_prescale.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prc_prescale: input decode and gain compensation
// Three register stages: sign/quadrant folding and axis detection, the
// 1/K multiplies, then rounding and sign restore into guard-bit format.
// ----------------------------------------------------------------------------
module prc_prescale #(
    parameter int DATA_WIDTH = prc_pkg::DATA_WIDTH_DEF,
    parameter int W          = DATA_WIDTH + prc_pkg::GUARD + 3
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  wire                          in_valid,
    input  wire                          action,
    input  wire signed [DATA_WIDTH-1:0]  a_in,
    input  wire signed [DATA_WIDTH-1:0]  b_in,
    output prc_pkg::ctl_t                ctl_o,
    output logic signed [W-1:0]          cx_o,
    output logic signed [W-1:0]          cy_o,
    output logic [prc_pkg::ANG_W-1:0]    z_o
);

    localparam int DW = DATA_WIDTH;
    localparam int ZW = prc_pkg::ANG_W;
    localparam int PW = DW + 32;
    localparam int MW = PW + 1 - prc_pkg::PRE_SHIFT;

    localparam logic [DW:0] HALF    = (DW+1)'(1) << (DW - 1);
    localparam logic [DW:0] QUARTER = (DW+1)'(1) << (DW - 2);
    localparam logic [ZW-1:0] PI_Z  = ZW'(1) << (ZW - 1);

    // stage A: fold and detect
    prc_pkg::ctl_t          ctl_a_reg, ctl_a_next;
    logic [DW-1:0]          mag_a_reg, mag_a_next;
    logic [DW-1:0]          mag_b_reg, mag_b_next;
    logic                   sgn_a_reg, sgn_a_next;
    logic                   sgn_b_reg, sgn_b_next;
    logic [ZW-1:0]          z_a_reg, z_a_next;
    logic signed [DW:0]     byp_f_a_reg, byp_f_a_next;
    logic signed [DW:0]     byp_s_a_reg, byp_s_a_next;

    // stage B: products
    prc_pkg::ctl_t          ctl_b_reg;
    logic [PW-1:0]          prod_a_reg, prod_b_reg;
    logic                   sgn_a_b_reg, sgn_b_b_reg;
    logic [ZW-1:0]          z_b_reg;
    logic signed [DW:0]     byp_f_b_reg, byp_s_b_reg;

    // stage C: guard-bit coordinates
    prc_pkg::ctl_t          ctl_c_reg;
    logic signed [W-1:0]    cx_c_reg, cx_c_next;
    logic signed [W-1:0]    cy_c_reg, cy_c_next;
    logic [ZW-1:0]          z_c_reg;

    logic [DW:0]            a_ext, b_ext, a_abs, b_abs;
    logic                   a_neg, b_neg, flip;
    logic [ZW-1:0]          z_rot;
    logic [PW:0]            sum_a, sum_b;
    logic [W-1:0]           m_a, m_b;

    always_comb begin
        a_neg = a_in[DW-1];
        b_neg = b_in[DW-1];
        a_ext = {a_in[DW-1], a_in};
        b_ext = {b_in[DW-1], b_in};
        a_abs = a_neg ? -a_ext : a_ext;
        b_abs = b_neg ? -b_ext : b_ext;

        z_rot = ZW'($unsigned(b_in)) << (ZW - DW);
        flip  = z_rot[ZW-1] ^ z_rot[ZW-2];

        ctl_a_next.valid  = in_valid;
        ctl_a_next.vec    = ~action;
        ctl_a_next.bypass = 1'b0;
        mag_a_next   = a_abs[DW-1:0];
        mag_b_next   = b_abs[DW-1:0];
        sgn_a_next   = 1'b0;
        sgn_b_next   = 1'b0;
        z_a_next     = '0;
        byp_f_a_next = '0;
        byp_s_a_next = '0;

        if (!action) begin
            if (b_in == '0) begin
                ctl_a_next.bypass = 1'b1;
                byp_f_a_next = a_abs;
                byp_s_a_next = a_neg ? HALF : '0;
            end else if (a_in == '0) begin
                ctl_a_next.bypass = 1'b1;
                byp_f_a_next = b_abs;
                byp_s_a_next = b_neg ? -QUARTER : QUARTER;
            end else begin
                // left half plane: rotate by pi first
                sgn_b_next = a_neg ^ b_neg;
                z_a_next   = a_neg ? PI_Z : '0;
            end
        end else begin
            // second and third quadrants: negate radius, shift angle by pi
            mag_b_next = '0;
            sgn_a_next = a_neg ^ flip;
            z_a_next   = flip ? (z_rot ^ PI_Z) : z_rot;
        end
    end

    always_comb begin
        sum_a = {1'b0, prod_a_reg} + (PW+1)'(1 << (prc_pkg::PRE_SHIFT - 1));
        sum_b = {1'b0, prod_b_reg} + (PW+1)'(1 << (prc_pkg::PRE_SHIFT - 1));
        m_a   = W'(sum_a[PW:prc_pkg::PRE_SHIFT]);
        m_b   = W'(sum_b[PW:prc_pkg::PRE_SHIFT]);
        if (ctl_b_reg.bypass) begin
            cx_c_next = W'(byp_f_b_reg);
            cy_c_next = W'(byp_s_b_reg);
        end else begin
            cx_c_next = sgn_a_b_reg ? -m_a : m_a;
            cy_c_next = sgn_b_b_reg ? -m_b : m_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end else if (en) begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_a_reg   <= mag_a_next;
            mag_b_reg   <= mag_b_next;
            sgn_a_reg   <= sgn_a_next;
            sgn_b_reg   <= sgn_b_next;
            z_a_reg     <= z_a_next;
            byp_f_a_reg <= byp_f_a_next;
            byp_s_a_reg <= byp_s_a_next;

            prod_a_reg  <= PW'(mag_a_reg) * PW'(prc_pkg::INV_GAIN);
            prod_b_reg  <= PW'(mag_b_reg) * PW'(prc_pkg::INV_GAIN);
            sgn_a_b_reg <= sgn_a_reg;
            sgn_b_b_reg <= sgn_b_reg;
            z_b_reg     <= z_a_reg;
            byp_f_b_reg <= byp_f_a_reg;
            byp_s_b_reg <= byp_s_a_reg;

            cx_c_reg    <= cx_c_next;
            cy_c_reg    <= cy_c_next;
            z_c_reg     <= z_b_reg;
        end
    end

    assign ctl_o = ctl_c_reg;
    assign cx_o  = cx_c_reg;
    assign cy_o  = cy_c_reg;
    assign z_o   = z_c_reg;

endmodule
`default_nettype wire

[rtl/prc_cordic_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prc_cordic_stage: one registered CORDIC micro-rotation
// Vectoring drives y toward zero, rotation drives z toward zero. Axis-case
// words pass through unchanged.
// ----------------------------------------------------------------------------
module prc_cordic_stage #(
    parameter int W   = prc_pkg::DATA_WIDTH_DEF + prc_pkg::GUARD + 3,
    parameter int IDX = 0
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          en,
    input  prc_pkg::ctl_t                ctl_i,
    input  wire signed [W-1:0]           cx_i,
    input  wire signed [W-1:0]           cy_i,
    input  wire [prc_pkg::ANG_W-1:0]     z_i,
    output prc_pkg::ctl_t                ctl_o,
    output logic signed [W-1:0]          cx_o,
    output logic signed [W-1:0]          cy_o,
    output logic [prc_pkg::ANG_W-1:0]    z_o
);

    localparam logic [prc_pkg::ANG_W-1:0] ATAN = prc_pkg::atan_entry(IDX);

    prc_pkg::ctl_t                 ctl_reg;
    logic signed [W-1:0]           cx_reg, cx_next;
    logic signed [W-1:0]           cy_reg, cy_next;
    logic [prc_pkg::ANG_W-1:0]     z_reg, z_next;
    logic signed [W-1:0]           dx, dy;
    logic                          neg;

    always_comb begin
        dx  = cy_i >>> IDX;
        dy  = cx_i >>> IDX;
        neg = ctl_i.vec ? ~cy_i[W-1] : z_i[prc_pkg::ANG_W-1];
        if (ctl_i.bypass) begin
            cx_next = cx_i;
            cy_next = cy_i;
            z_next  = z_i;
        end else if (neg) begin
            cx_next = cx_i + dx;
            cy_next = cy_i - dy;
            z_next  = z_i + ATAN;
        end else begin
            cx_next = cx_i - dx;
            cy_next = cy_i + dy;
            z_next  = z_i - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            z_reg  <= z_next;
        end
    end

    assign ctl_o = ctl_reg;
    assign cx_o  = cx_reg;
    assign cy_o  = cy_reg;
    assign z_o   = z_reg;

endmodule
`default_nettype wire

[rtl/prc_output.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prc_output: result rounding, saturation and output buffering
// Rounds coordinates out of guard format, rounds the angle to DATA_WIDTH
// bits, and holds results in an output register plus a one-word skid.
// ----------------------------------------------------------------------------
module prc_output #(
    parameter int DATA_WIDTH = prc_pkg::DATA_WIDTH_DEF,
    parameter int W          = DATA_WIDTH + prc_pkg::GUARD + 3
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  prc_pkg::ctl_t                ctl_i,
    input  wire signed [W-1:0]           cx_i,
    input  wire signed [W-1:0]           cy_i,
    input  wire [prc_pkg::ANG_W-1:0]     z_i,
    output logic                         pipe_en,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [DATA_WIDTH:0]   m_first_out,
    output logic signed [DATA_WIDTH:0]   m_second_out
);

    localparam int DW = DATA_WIDTH;
    localparam int ZW = prc_pkg::ANG_W;
    localparam int QW = W - prc_pkg::GUARD;

    localparam logic signed [QW-1:0] SAT_HI = {{(QW-DW){1'b0}}, {DW{1'b1}}};
    localparam logic signed [QW-1:0] SAT_LO = {{(QW-DW){1'b1}}, {DW{1'b0}}};
    localparam logic [W-1:0]         RND    = W'(1) << (prc_pkg::GUARD - 1);
    localparam logic [ZW+DW-1:0]     ARND   = (ZW+DW)'(1) << (ZW - 1);
    localparam logic [DW-1:0]        NEG_PI = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW:0]          POS_PI = {2'b01, {(DW-1){1'b0}}};

    logic                  out_valid_reg;
    logic signed [DW:0]    out_f_reg, out_s_reg;
    logic                  skid_valid_reg;
    logic signed [DW:0]    skid_f_reg, skid_s_reg;

    logic                  push;
    logic signed [DW:0]    res_f, res_s;

    function automatic logic [DW:0] finish(input logic signed [W-1:0] v);
        logic [W-1:0]         sum;
        logic signed [QW-1:0] q;
        logic [DW:0]          r;
        sum = v + RND;
        q   = sum[W-1:prc_pkg::GUARD];
        if (q > SAT_HI) begin
            r = SAT_HI[DW:0];
        end else if (q < SAT_LO) begin
            r = SAT_LO[DW:0];
        end else begin
            r = q[DW:0];
        end
        return r;
    endfunction

    function automatic logic [DW:0] angle_round(input logic [ZW-1:0] z);
        logic [ZW+DW-1:0] zs;
        logic [DW-1:0]    t;
        zs = {z, {DW{1'b0}}} + ARND;
        t  = zs[ZW+DW-1:ZW];
        // -pi is reported as +pi
        return (t == NEG_PI) ? POS_PI : {t[DW-1], t};
    endfunction

    always_comb begin
        push = pipe_en & ctl_i.valid;
        if (ctl_i.bypass) begin
            res_f = cx_i[DW:0];
            res_s = cy_i[DW:0];
        end else begin
            res_f = finish(cx_i);
            res_s = ctl_i.vec ? angle_round(z_i) : finish(cy_i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_ready) begin
            if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= push;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_ready) begin
            if (push) begin
                skid_f_reg <= res_f;
                skid_s_reg <= res_s;
            end
        end else if (skid_valid_reg) begin
            out_f_reg <= skid_f_reg;
            out_s_reg <= skid_s_reg;
        end else begin
            out_f_reg <= res_f;
            out_s_reg <= res_s;
        end
    end

    assign pipe_en      = ~skid_valid_reg;
    assign m_valid      = out_valid_reg;
    assign m_first_out  = out_f_reg;
    assign m_second_out = out_s_reg;

    // skid holds a word only behind a held output word
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full with output register empty");

    // skid fills only on a stalled output
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready && push))
        else $error("skid filled without a stall");

    // a push into a stalled output never finds the skid occupied
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl_i.valid && out_valid_reg && !m_ready && skid_valid_reg) |=>
        (skid_valid_reg && out_valid_reg))
        else $error("result word overrun");

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for polar_rect_converter_core
// Drives coordinate pairs in both directions (rect to polar, polar to rect),
// predicts each result with an independent fixed-point CORDIC model and
// compares every output word against the oldest pending prediction, under
// random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DW         = prc_pkg::DATA_WIDTH_DEF;
    localparam int ITER       = prc_pkg::ITERATIONS_DEF;
    localparam int TAB_LEN    = 24;
    localparam int GUARD_BITS = 24;
    localparam int CYCLE_LIMIT = 200000;
    // pipeline is ITER + 4 deep plus a skid slot; drain a bit longer than that
    localparam int DRAIN_CYCLES = ITER + 16;

    // 1/K of the CORDIC gain, Q0.32
    localparam longint GAIN_INV = 64'h0000_0000_9B74_EDA8;

    // atan(2^-i) in binary angle units, 2^31 = pi
    localparam logic [31:0] ATAN_TAB [0:TAB_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic signed [DW-1:0] FIELD_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] FIELD_MAX = {1'b0, {(DW-1){1'b1}}};

    typedef enum logic {
        ACT_TO_POLAR = 1'b0,
        ACT_TO_RECT  = 1'b1
    } action_e;

    typedef struct packed {
        logic signed [DW:0] first;
        logic signed [DW:0] second;
    } coord_pair_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic                 s_action     = 1'b0;
    logic signed [DW-1:0] s_a_in       = '0;
    logic signed [DW-1:0] s_b_in       = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic signed [DW:0]   m_first_out;
    logic signed [DW:0]   m_second_out;

    // predictions waiting for their output word, oldest first
    coord_pair_t expected_results[$];
    coord_pair_t want_pair;

    int errors          = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int cycle_count     = 0;

    // idling controls: sender bursts, receiver bursts, receiver hold-off
    bit tx_bursts  = 1'b0;
    bit rx_bursts  = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;

    polar_rect_converter_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_a_in       (s_a_in),
        .s_b_in       (s_b_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_first_out  (m_first_out),
        .m_second_out (m_second_out)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor: fixed-point CORDIC, coordinates carry GUARD_BITS of fraction
    // ------------------------------------------------------------------------

    // multiply by 1/K, rounding the magnitude half up, sign restored after
    function automatic longint gain_comp(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag * GAIN_INV + (64'sd1 <<< (31 - GUARD_BITS))) >>> (32 - GUARD_BITS);
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp_coord(longint v);
        longint hi, lo;
        hi = (64'sd1 <<< DW) - 1;
        lo = -(64'sd1 <<< DW);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // drop guard bits, round half up, then saturate
    function automatic longint round_coord(longint v);
        return clamp_coord((v + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS);
    endfunction

    // 32-bit binary angle down to DW bits; -pi folds onto +pi
    function automatic longint angle_to_field(logic [31:0] z);
        logic [63:0] t;
        logic [63:0] half;
        half = 64'd1 << (DW - 1);
        t = (({32'd0, z} << DW) + 64'h8000_0000) >> 32;
        t = t & ((64'd1 << DW) - 1);
        if (t == half)
            return longint'(half);
        else if (t > half)
            return longint'(t) - (64'sd1 <<< DW);
        return longint'(t);
    endfunction

    function automatic coord_pair_t convert_coords(action_e act,
                                                   logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
        longint x, y, cx, cy, dx, dy, fx, fy;
        logic [31:0] z;
        int n;
        coord_pair_t res;
        n  = (ITER > TAB_LEN) ? TAB_LEN : ITER;
        x  = longint'(a);
        y  = longint'(b);
        z  = '0;
        if (act == ACT_TO_POLAR) begin
            if (y == 0) begin
                // on the horizontal axis: exact, x < 0 gives +pi
                fx = clamp_coord((x < 0) ? -x : x);
                fy = (x < 0) ? (64'sd1 <<< (DW - 1)) : 0;
            end else if (x == 0) begin
                // vertical axis: exact quarter turn
                fx = clamp_coord((y < 0) ? -y : y);
                fy = (y < 0) ? -(64'sd1 <<< (DW - 2)) : (64'sd1 <<< (DW - 2));
            end else begin
                // left half plane: reflect through the origin, start at pi
                if (x < 0) begin
                    x = -x;
                    y = -y;
                    z = 32'h8000_0000;
                end
                cx = gain_comp(x);
                cy = gain_comp(y);
                for (int i = 0; i < n; i++) begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (cy >= 0) begin
                        cx = cx + dx;
                        cy = cy - dy;
                        z  = z + ATAN_TAB[i];
                    end else begin
                        cx = cx - dx;
                        cy = cy + dy;
                        z  = z - ATAN_TAB[i];
                    end
                end
                fx = round_coord(cx);
                fy = angle_to_field(z);
            end
        end else begin
            z  = 32'(y << (32 - DW));
            cx = gain_comp(x);
            cy = 0;
            // second or third quadrant: negate radius and turn by pi
            if (z[31:30] == 2'b01 || z[31:30] == 2'b10) begin
                cx = -cx;
                z  = z + 32'h8000_0000;
            end
            for (int i = 0; i < n; i++) begin
                dx = cy >>> i;
                dy = cx >>> i;
                if (!z[31]) begin
                    cx = cx - dx;
                    cy = cy + dy;
                    z  = z - ATAN_TAB[i];
                end else begin
                    cx = cx + dx;
                    cy = cy - dy;
                    z  = z + ATAN_TAB[i];
                end
            end
            fx = round_coord(cx);
            fy = round_coord(cy);
        end
        res.first  = fx[DW:0];
        res.second = fy[DW:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one word per call, entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_word(action_e act, logic signed [DW-1:0] a,
                             logic signed [DW-1:0] b);
        int gap;
        gap = 0;
        if (tx_bursts && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_action <= act;
        s_a_in   <= a;
        s_b_in   <= b;
        // s_ready is registered, so its value here holds through the next edge
        while (!s_ready) @(negedge aclk);
        expected_results.push_back(convert_coords(act, a, b));
        words_sent++;
        @(negedge aclk);
    endtask

    // mostly full range, with a share of extremes and small values
    function automatic logic signed [DW-1:0] pick_field();
        int sel;
        logic signed [DW-1:0] v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: begin
                case ($urandom_range(0, 4))
                    0:       v = FIELD_MIN;
                    1:       v = FIELD_MAX;
                    2:       v = '0;
                    3:       v = '1;
                    default: v = DW'(1);
                endcase
            end
            1:       v = DW'(int'($urandom_range(0, 31)) - 16);
            default: v = DW'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_random_word();
        action_e act;
        logic signed [DW-1:0] a, b;
        act = action_e'($urandom_range(0, 1));
        a   = pick_field();
        b   = pick_field();
        // push some words onto an axis to hit the exact paths
        case ($urandom_range(0, 11))
            0:       a = '0;
            1:       b = '0;
            default: ;
        endcase
        send_word(act, a, b);
    endtask

    // ------------------------------------------------------------------------
    // Test phases
    // ------------------------------------------------------------------------

    // origin, both axes, corners, the -pi fold and negative radius
    task automatic test_directed();
        send_word(ACT_TO_POLAR, 16'sd0, 16'sd0);
        send_word(ACT_TO_POLAR, FIELD_MAX, 16'sd0);
        send_word(ACT_TO_POLAR, FIELD_MIN, 16'sd0);
        send_word(ACT_TO_POLAR, 16'sd0, FIELD_MAX);
        send_word(ACT_TO_POLAR, 16'sd0, FIELD_MIN);
        send_word(ACT_TO_POLAR, FIELD_MAX, FIELD_MAX);
        send_word(ACT_TO_POLAR, FIELD_MIN, FIELD_MIN);
        send_word(ACT_TO_POLAR, FIELD_MIN, FIELD_MAX);
        send_word(ACT_TO_POLAR, FIELD_MAX, FIELD_MIN);
        // just above and just below the negative x axis: both report +pi
        send_word(ACT_TO_POLAR, FIELD_MIN, 16'sd1);
        send_word(ACT_TO_POLAR, FIELD_MIN, -16'sd1);
        send_word(ACT_TO_POLAR, 16'sd1, -16'sd1);
        send_word(ACT_TO_POLAR, -16'sd1, 16'sd1);
        send_word(ACT_TO_RECT, FIELD_MAX, 16'sd0);
        send_word(ACT_TO_RECT, FIELD_MAX, 16'sd16384);
        send_word(ACT_TO_RECT, FIELD_MAX, -16'sd16384);
        send_word(ACT_TO_RECT, FIELD_MAX, FIELD_MIN);
        send_word(ACT_TO_RECT, FIELD_MAX, FIELD_MAX);
        send_word(ACT_TO_RECT, FIELD_MIN, 16'sd8192);
        send_word(ACT_TO_RECT, FIELD_MIN, FIELD_MIN);
        send_word(ACT_TO_RECT, 16'sd0, 16'sd12345);
        send_word(ACT_TO_RECT, -16'sd1, -16'sd1);
        send_word(ACT_TO_RECT, 16'sd1, 16'sd24576);
    endtask

    task automatic test_random_mixed(int count);
        tx_bursts = 1'b1;
        rx_bursts = 1'b1;
        repeat (count) send_random_word();
    endtask

    // receiver stops for a long stretch while words keep coming, so the
    // pipeline and skid fill and s_ready has to drop
    task automatic test_back_pressure(int count);
        tx_bursts = 1'b0;
        rx_bursts = 1'b0;
        hold_left = 300;
        repeat (count) send_random_word();
    endtask

    // final stretch at full rate, no idling on either side
    task automatic test_streaming(int count);
        tx_bursts = 1'b0;
        rx_bursts = 1'b0;
        repeat (count) send_random_word();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready driven at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (rx_bursts && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(1, 10) - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result check at the rising edge, against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word first=%0d second=%0d",
                         $time, m_first_out, m_second_out);
            end else begin
                want_pair = expected_results.pop_front();
                results_checked++;
                if (m_first_out !== want_pair.first) begin
                    errors++;
                    $display("%0t: first_out mismatch expected %0d actual %0d",
                             $time, want_pair.first, m_first_out);
                end
                if (m_second_out !== want_pair.second) begin
                    errors++;
                    $display("%0t: second_out mismatch expected %0d actual %0d",
                             $time, want_pair.second, m_second_out);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d predictions still pending",
                     $time, expected_results.size());
            $display("[polar_rect_converter_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_mixed(700);
        test_back_pressure(80);
        test_random_mixed(60);
        test_streaming(300);

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words in both directions, checked %0d results,",
                 words_sent, results_checked);
        $display("incl. axis cases, the pi fold, and a long output stall.");
        if (errors == 0) begin
            $display("[polar_rect_converter_core] OK");
        end else begin
            $display("[polar_rect_converter_core] ERROR");
        end
        $finish;
    end

endmodule
